>>> hdl/ssg_pkg.sv
// Shared constants, types and item layout for the smoothed stereo gain block.
`timescale 1ns / 1ps
package ssg_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int GAIN_FRAC_BITS = 24;
   localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
   localparam int COEF_BITS      = 24;
   localparam int SNAP_BITS      = 25;
   localparam int REQ_GAIN_BITS  = 32;

   localparam int REQ_FIELD_BITS = 2 * SAMPLE_BITS + REQ_GAIN_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * SAMPLE_BITS + GAIN_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int CSR_DATA_BITS  = (COEF_BITS > SNAP_BITS) ? COEF_BITS : SNAP_BITS;
   localparam int CSR_INDEX_BITS = 1;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(1) << GAIN_FRAC_BITS;
   localparam logic [SNAP_BITS-1:0] SNAP_RESET = SNAP_BITS'(168);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_COEF = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SNAP_DIST = 1'b1;

   localparam logic ACTION_FRAME  = 1'b0;
   localparam logic ACTION_TARGET = 1'b1;

   typedef struct packed {
      logic                          action;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic [GAIN_BITS-1:0]          target;
   } ssg_entry_type;

endpackage

>>> hdl/ssg_front.sv
// Front end: accept items, clamp requested gains and push classified entries to the queue.
`timescale 1ns / 1ps
module ssg_front
   import ssg_pkg::*;
(
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tuser,
   input  logic                     queue_full,
   output logic                     push,
   output ssg_entry_type            push_entry
);

   logic signed [REQ_GAIN_BITS-1:0] req_gain;
   logic [GAIN_BITS-1:0]            clamped;

   assign req_gain = req_tdata[2*SAMPLE_BITS +: REQ_GAIN_BITS];

   always_comb begin
      priority if (req_gain[REQ_GAIN_BITS-1]) begin
         clamped = '0;
      end else if (req_gain > $signed(REQ_GAIN_BITS'(UNITY_GAIN))) begin
         clamped = UNITY_GAIN;
      end else begin
         clamped = req_gain[GAIN_BITS-1:0];
      end
   end

   assign req_tready        = !queue_full;
   assign push              = req_tvalid && !queue_full;
   assign push_entry.action = req_tuser;
   assign push_entry.left   = req_tdata[0 +: SAMPLE_BITS];
   assign push_entry.right  = req_tdata[SAMPLE_BITS +: SAMPLE_BITS];
   assign push_entry.target = clamped;

endmodule

>>> hdl/ssg_queue.sv
// Two-entry queue between the front end and the gain engine.
`timescale 1ns / 1ps
module ssg_queue
   import ssg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ssg_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output ssg_entry_type pop_entry,
   output logic          empty
);

   ssg_entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;

   assign full      = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/ssg_back.sv
// Gain engine: holds the gain state and settings, ramps the gain and scales the samples.
`timescale 1ns / 1ps
module ssg_back
   import ssg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic                      queue_empty,
   input  ssg_entry_type             pop_entry,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_APPLY = 1'b1;
   localparam int   PROD_BITS = COEF_BITS + GAIN_BITS + 2;
   localparam int   OUT_BITS  = SAMPLE_BITS + GAIN_BITS + 1;

   logic                           state_ff, state_in;
   logic [COEF_BITS-1:0]           coef_ff;
   logic [SNAP_BITS-1:0]           snap_dist_ff;
   logic [GAIN_BITS-1:0]           current_ff, target_ff;
   logic signed [PROD_BITS-1:0]    product_ff;
   logic                           snap_ff, diff_neg_ff;
   logic signed [SAMPLE_BITS-1:0]  left_ff, right_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]  left_out_ff, right_out_ff;
   logic [GAIN_BITS-1:0]           gain_out_ff;

   logic signed [GAIN_BITS:0]      diff;
   logic [GAIN_BITS-1:0]           gain_dist;
   logic signed [COEF_BITS:0]      coef_s;
   logic signed [PROD_BITS-1:0]    product;
   logic signed [GAIN_BITS:0]      step, step_fix;
   logic [GAIN_BITS-1:0]           new_gain;
   logic signed [GAIN_BITS:0]      gain_s;
   logic signed [OUT_BITS-1:0]     left_prod, right_prod;
   logic                           out_free, start_frame, finish;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign pop         = (state_ff == ST_IDLE) && !queue_empty;
   assign start_frame = pop && (pop_entry.action == ACTION_FRAME);
   assign finish      = (state_ff == ST_APPLY) && out_free;

   assign diff      = $signed({1'b0, target_ff}) - $signed({1'b0, current_ff});
   assign gain_dist = diff[GAIN_BITS] ? GAIN_BITS'(-diff) : diff[GAIN_BITS-1:0];
   assign coef_s    = $signed({1'b0, coef_ff});
   assign product   = PROD_BITS'(coef_s) * PROD_BITS'(diff);

   assign step     = product_ff[COEF_BITS +: GAIN_BITS + 1];
   assign step_fix = (step != '0) ? step :
                     (diff_neg_ff ? -$signed((GAIN_BITS + 1)'(1)) : $signed((GAIN_BITS + 1)'(1)));
   assign new_gain = snap_ff ? target_ff
                             : GAIN_BITS'($signed({1'b0, current_ff}) + step_fix);
   assign gain_s     = $signed({1'b0, new_gain});
   assign left_prod  = OUT_BITS'(left_ff) * OUT_BITS'(gain_s);
   assign right_prod = OUT_BITS'(right_ff) * OUT_BITS'(gain_s);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_frame) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         coef_ff      <= '0;
         snap_dist_ff <= SNAP_RESET;
         current_ff   <= UNITY_GAIN;
         target_ff    <= UNITY_GAIN;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_RAMP_COEF: coef_ff      <= csr_data[COEF_BITS-1:0];
               CSR_SNAP_DIST: snap_dist_ff <= csr_data[SNAP_BITS-1:0];
               default: ;
            endcase
         end
         if (pop && (pop_entry.action == ACTION_TARGET)) begin
            target_ff <= pop_entry.target;
         end
         if (finish) begin
            current_ff <= new_gain;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_frame) begin
         product_ff  <= product;
         snap_ff     <= (coef_ff == '0) || (SNAP_BITS'(gain_dist) <= snap_dist_ff);
         diff_neg_ff <= diff[GAIN_BITS];
         left_ff     <= pop_entry.left;
         right_ff    <= pop_entry.right;
      end
      if (finish) begin
         left_out_ff  <= left_prod[GAIN_FRAC_BITS +: SAMPLE_BITS];
         right_out_ff <= right_prod[GAIN_FRAC_BITS +: SAMPLE_BITS];
         gain_out_ff  <= new_gain;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}},
                        gain_out_ff, right_out_ff, left_out_ff};

endmodule

>>> hdl/smoothed_stereo_gain.sv
// Path: a frame result is registered in the two-entry queue, then with its step product, then in the
// output register; it waits when earlier items are ahead of it or the output stalls.
// Throughput: one set-target item per cycle while the gain engine is idle; it takes no
// new item while applying a frame (step multiply, then gain update and sample multiply).
// Reset: synchronous, active high; gain and target return to unity, ramp coefficient to 0,
// snap distance to 168, queue and output register empty.
`timescale 1ns / 1ps
module smoothed_stereo_gain
   import ssg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // left_in, right_in, requested_gain
   input  logic                      req_tuser,   // action
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // left_out, right_out, gain_applied, zero pad
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic          push, queue_full, queue_empty, pop;
   ssg_entry_type push_entry, pop_entry;

   ssg_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   ssg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   ssg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

>>> hdl/ssg_checker.sv
// Port-level checks for the smoothed stereo gain block, bound to the top level.
`timescale 1ns / 1ps
module ssg_port_checker
   import ssg_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_DATA_BITS-1:0]  req_tdata,
   input logic                      req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                      csr_we,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [GAIN_BITS-1:0]   gain_applied;
   logic [SAMPLE_BITS-1:0] left_out, right_out;

   assign left_out     = rsp_tdata[0 +: SAMPLE_BITS];
   assign right_out    = rsp_tdata[SAMPLE_BITS +: SAMPLE_BITS];
   assign gain_applied = rsp_tdata[2*SAMPLE_BITS +: GAIN_BITS];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> gain_applied <= UNITY_GAIN)
      else $error("applied gain above unity");

   a_mute: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && gain_applied == '0 |-> left_out == '0 && right_out == '0)
      else $error("nonzero sample at zero gain");

endmodule

bind smoothed_stereo_gain ssg_port_checker u_ssg_checker (.*);

>>> test/ssg_checker.sv
// Checker for the stereo gain stage: tracks gain and target, predicts each frame result and compares.
`timescale 1ns / 1ps
module ssg_checker
   import ssg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // left_in, right_in, requested_gain
   input  logic                      req_tuser,   // action
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // left_out, right_out, gain_applied, zero pad
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        fail_count,
   output int                        pending_frames
);

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic [GAIN_BITS-1:0]          gain;
   } frame_result_type;

   logic [GAIN_BITS-1:0]          gain_now;
   logic [GAIN_BITS-1:0]          gain_goal;
   logic [COEF_BITS-1:0]          ramp_coef;
   logic [SNAP_BITS-1:0]          snap_dist;
   frame_result_type              expected_frames[$];
   frame_result_type              want_res;
   logic signed [SAMPLE_BITS-1:0] got_left;
   logic signed [SAMPLE_BITS-1:0] got_right;
   logic [GAIN_BITS-1:0]          got_gain;

   initial begin
      fail_count     = 0;
      pending_frames = 0;
   end

   function automatic void store_target(logic signed [REQ_GAIN_BITS-1:0] want);
      longint w;
      w = want;
      if (w < 0) begin
         gain_goal = '0;
      end else if (w > longint'(UNITY_GAIN)) begin
         gain_goal = UNITY_GAIN;
      end else begin
         gain_goal = GAIN_BITS'(w);
      end
   endfunction

   function automatic frame_result_type scale_frame(logic signed [SAMPLE_BITS-1:0] l,
                                                    logic signed [SAMPLE_BITS-1:0] r);
      longint           diff;
      longint           distance;
      longint           step;
      longint           g;
      longint           ls;
      longint           rs;
      frame_result_type res;
      diff = longint'(gain_goal) - longint'(gain_now);
      distance = (diff < 0) ? -diff : diff;
      if (ramp_coef == '0 || distance <= longint'(snap_dist)) begin
         gain_now = gain_goal;
      end else begin
         step = (longint'(ramp_coef) * diff) >>> COEF_BITS;
         if (step == 0) begin
            step = (diff > 0) ? 1 : -1;
         end
         gain_now = GAIN_BITS'(longint'(gain_now) + step);
      end
      g  = longint'(gain_now);
      ls = l;
      rs = r;
      res.left  = SAMPLE_BITS'((ls * g) >>> GAIN_FRAC_BITS);
      res.right = SAMPLE_BITS'((rs * g) >>> GAIN_FRAC_BITS);
      res.gain  = gain_now;
      return res;
   endfunction

   function automatic void report(string field, longint want, longint got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         gain_now  = UNITY_GAIN;
         gain_goal = UNITY_GAIN;
         ramp_coef = '0;
         snap_dist = SNAP_RESET;
         expected_frames.delete();
         pending_frames = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_RAMP_COEF) begin
               ramp_coef = csr_data[COEF_BITS-1:0];
            end else if (csr_index == CSR_SNAP_DIST) begin
               snap_dist = csr_data[SNAP_BITS-1:0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
            end else begin
               want_res  = expected_frames.pop_front();
               got_left  = rsp_tdata[SAMPLE_BITS-1:0];
               got_right = rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
               got_gain  = rsp_tdata[2*SAMPLE_BITS +: GAIN_BITS];
               if (got_left !== want_res.left) begin
                  report("left_out", want_res.left, got_left);
               end
               if (got_right !== want_res.right) begin
                  report("right_out", want_res.right, got_right);
               end
               if (got_gain !== want_res.gain) begin
                  report("gain_applied", want_res.gain, got_gain);
               end
               if (rsp_tdata[RSP_DATA_BITS-1:RSP_FIELD_BITS] !== '0) begin
                  report("padding", 0, rsp_tdata[RSP_DATA_BITS-1:RSP_FIELD_BITS]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACTION_TARGET) begin
               store_target(req_tdata[2*SAMPLE_BITS +: REQ_GAIN_BITS]);
            end else begin
               expected_frames.push_back(scale_frame(req_tdata[SAMPLE_BITS-1:0],
                                                     req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
            end
         end
         pending_frames = expected_frames.size();
      end
   end

endmodule

>>> test/testbench.sv
// Top of the stereo gain stage test: clock, reset, register writes, item stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
   import ssg_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 115;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;   // left_in, right_in, requested_gain
   logic                      req_tuser;   // action
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;   // left_out, right_out, gain_applied, zero pad
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        fail_count;
   int                        pending_frames;
   int                        cycle_count = 0;
   int                        items_sent = 0;
   int                        burst_left = 0;
   int                        hold_asked = 0;
   int                        hold_done = 0;

   smoothed_stereo_gain i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ssg_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending_frames (pending_frames)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int pick_gap(int n);
      int r;
      r = $urandom_range(0, 99);
      if ((n / 150) % 4 == 1 || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         2: return SAMPLE_BITS'(int'($urandom_range(0, 31)) - 16);
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   function automatic logic [REQ_GAIN_BITS-1:0] pick_request();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return {1'b1, 31'($urandom())};
         2: return $urandom_range(32'h0100_0001, 32'h7FFF_FFFF);
         3: return '0;
         4: return REQ_GAIN_BITS'(UNITY_GAIN);
         default: return $urandom_range(0, 32'h0100_0000);
      endcase
   endfunction

   task automatic send_item(input logic                     action,
                            input logic [SAMPLE_BITS-1:0]   l,
                            input logic [SAMPLE_BITS-1:0]   r,
                            input logic [REQ_GAIN_BITS-1:0] want);
      int gap;
      gap = (burst_left > 0) ? 0 : pick_gap(items_sent);
      if (burst_left > 0) begin
         burst_left--;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {want, r, l};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0]  value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_frames != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // receiver: random back-pressure, quiet stretches, and a long hold on request
   initial begin : rsp_side
      int rx_cycle;
      int idle_left;
      int r;
      rx_cycle  = 0;
      idle_left = 0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (hold_asked != hold_done) begin
            hold_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_tready <= 1'b0;
         end else if ((rx_cycle / 200) % 4 == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               idle_left  = $urandom_range(0, 2);
               rsp_tready <= 1'b0;
            end else if (r < 15) begin
               idle_left  = $urandom_range(8, 30);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] coef;
      logic [CSR_DATA_BITS-1:0] snap;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACTION_FRAME;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_RAMP_COEF;
      csr_data   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unity gain, jump mode
      send_item(ACTION_FRAME, 24'h7FFFFF, 24'h800000, '0);
      send_item(ACTION_FRAME, 24'hFFFFFF, 24'h000001, $urandom());
      send_item(ACTION_TARGET, 24'h5A5A5A, 24'hA5A5A5, 32'hFFFF_FFFF);
      send_item(ACTION_FRAME, 24'h7FFFFF, 24'h800000, '0);
      send_item(ACTION_TARGET, '0, '0, 32'h7FFF_FFFF);
      send_item(ACTION_FRAME, 24'h123456, 24'hFEDCBA, '0);
      send_item(ACTION_TARGET, '0, '0, 32'h8000_0000);
      send_item(ACTION_TARGET, '0, '0, 32'h0100_0000);
      send_item(ACTION_TARGET, '0, '0, 32'h0080_0000);
      send_item(ACTION_FRAME, 24'h800000, 24'hFFFFFF, '0);
      send_item(ACTION_TARGET, '0, '0, 32'h0100_0001);
      send_item(ACTION_FRAME, pick_sample(), pick_sample(), 32'h0000_0000);

      // widest coefficient, masked to its width; no snapping
      drain();
      write_reg(CSR_RAMP_COEF, '1);
      write_reg(CSR_SNAP_DIST, '0);
      send_item(ACTION_TARGET, '0, '0, '0);
      send_item(ACTION_FRAME, 24'h7FFFFF, 24'h800000, '0);
      send_item(ACTION_FRAME, 24'h7FFFFF, 24'h800000, '0);

      // smallest coefficient: steps forced to one LSB
      drain();
      write_reg(CSR_RAMP_COEF, CSR_DATA_BITS'(1));
      send_item(ACTION_TARGET, '0, '0, 32'h0100_0000);
      send_item(ACTION_FRAME, 24'h7FFFFF, 24'h800000, '0);
      send_item(ACTION_TARGET, '0, '0, 32'h00FF_FFFB);
      send_item(ACTION_FRAME, 24'h7FFFFF, 24'h800000, '0);
      send_item(ACTION_FRAME, 24'h7FFFFF, 24'h800000, '0);
      send_item(ACTION_FRAME, 24'h7FFFFF, 24'h800000, '0);

      // snap distance of unity gain: always lands on target
      drain();
      write_reg(CSR_SNAP_DIST, CSR_DATA_BITS'(UNITY_GAIN));
      send_item(ACTION_TARGET, '0, '0, '0);
      send_item(ACTION_FRAME, 24'h7FFFFF, 24'h800000, '0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin coef = 'h400; snap = '0; end
            1: begin coef = CSR_DATA_BITS'($urandom_range(1, 255));
                      snap = CSR_DATA_BITS'($urandom_range(0, 4096)); end
            2: begin coef = '0; snap = '0; end
            3: begin coef = CSR_DATA_BITS'($urandom_range(1 << 16, 1 << 22));
                      snap = CSR_DATA_BITS'(SNAP_RESET); end
            4: begin coef = 'hFFFFFF; snap = '0; end
            5: begin coef = CSR_DATA_BITS'($urandom()); snap = CSR_DATA_BITS'(UNITY_GAIN); end
            6: begin coef = CSR_DATA_BITS'($urandom_range(1 << 20, (1 << 24) - 1));
                      snap = CSR_DATA_BITS'($urandom_range(0, 255)); end
            7: begin coef = 'd1; snap = 'd1; end
            8: begin coef = CSR_DATA_BITS'($urandom()); snap = CSR_DATA_BITS'($urandom()); end
            default: begin coef = CSR_DATA_BITS'($urandom_range(1 << 12, 1 << 18));
                           snap = CSR_DATA_BITS'(SNAP_RESET); end
         endcase
         drain();
         write_reg(CSR_RAMP_COEF, coef);
         write_reg(CSR_SNAP_DIST, snap);
         if (phase == 3) begin
            hold_asked++;
            burst_left = 40;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 18) begin
               send_item(ACTION_TARGET, SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()),
                         pick_request());
            end else begin
               send_item(ACTION_FRAME, pick_sample(), pick_sample(), $urandom());
            end
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/ssg_pkg.sv
hdl/ssg_front.sv
hdl/ssg_queue.sv
hdl/ssg_back.sv
hdl/smoothed_stereo_gain.sv
hdl/ssg_checker.sv
test/ssg_checker.sv
test/testbench.sv
